[rtl/core/coax_rotor_command_mixer_defines.svh]
// ----------------------------------------------------------------------------
// Coax rotor command mixer assertion macros
// Shared property forms for the checks in the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef COAX_ROTOR_COMMAND_MIXER_DEFINES_SVH
`define COAX_ROTOR_COMMAND_MIXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRMX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crmx check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crmx check failed");

`endif

[rtl/core/crmx_pkg.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer package
// Beat types, register layout, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package crmx_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned XW = 33;
  localparam int unsigned ZW = 20;

  localparam logic signed [14:0] PHASE_PI = 15'sd12868;
  localparam logic signed [16:0] PHASE_PI_W = 17'sd12868;
  localparam logic signed [16:0] PHASE_TWO_PI = 17'sd25736;
  localparam logic [15:0] SLOW_SPEED = 16'd1600;
  localparam logic signed [ZW-1:0] HALF_PI_FINE = 20'sd102944;

  localparam logic signed [ZW-1:0] ATAN_FINE [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30385, 20'sd16054, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

  typedef enum logic [2:0] {
    REG_THRUST_LIMIT    = 3'd0,
    REG_YAW_LIMIT       = 3'd1,
    REG_PULSE_THRESHOLD = 3'd2,
    REG_PULSE_OFFSET    = 3'd3,
    REG_PULSE_LIMIT     = 3'd4,
    REG_PHASE_ADVANCE   = 3'd5,
    REG_BOTTOM_ENABLE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] thrust_limit;
    logic [14:0] yaw_limit;
    logic [14:0] pulse_threshold;
    logic [14:0] pulse_offset;
    logic [14:0] pulse_limit;
    logic [14:0] phase_advance;
    logic        bottom_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    thrust_limit:    15'd5734,
    yaw_limit:       15'd1536,
    pulse_threshold: 15'd57,
    pulse_offset:    15'd1536,
    pulse_limit:     15'd4096,
    phase_advance:   15'h7333,
    bottom_enable:   1'b1
  };

  typedef struct packed {
    logic [15:0] thrust_cmd;
    logic [15:0] yaw_cmd;
    logic [15:0] roll_cmd;
    logic [15:0] pitch_cmd;
    logic [15:0] rotor_speed;
  } cmd_t;

  typedef struct packed {
    logic [16:0] upper_drive;
    logic [16:0] lower_drive;
    logic [14:0] pulse_amplitude;
    logic [14:0] pulse_phase;
    logic [14:0] raw_phase;
  } drv_t;

  typedef struct packed {
    logic [16:0] upper_drive;
    logic [16:0] lower_drive;
    logic        slow;
  } carry_t;

  typedef struct packed {
    carry_t        carry;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [ZW-1:0] z;
    logic          zero;
    logic [31:0]   s;
    logic [31:0]   r;
  } work_t;

endpackage

[rtl/core/crmx_front.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer front end
// Clamps thrust and yaw, squares roll and pitch, and sets up the first cell.
// ----------------------------------------------------------------------------
module crmx_front (
  input  logic                  clk,
  input  logic                  rst,
  input  crmx_pkg::cfg_t        cfg,
  input  logic                  up_valid,
  input  crmx_pkg::cmd_t        up,
  output logic                  up_ready,
  output logic                  valid,
  output crmx_pkg::work_t       q,
  input  logic                  dn_ready
);

  typedef struct packed {
    logic [15:0] thrust;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [31:0] rsq;
    logic [31:0] psq;
    logic        slow;
  } front_t;

  logic s1_valid;
  front_t s1;
  front_t s1_next;
  crmx_pkg::work_t q_next;
  logic ready;

  logic signed [16:0] tl;
  logic signed [16:0] thr;
  logic signed [16:0] thr_c;
  logic signed [31:0] rsq_s;
  logic signed [31:0] psq_s;

  logic signed [17:0] t;
  logic signed [17:0] yw;
  logic signed [17:0] y1;
  logic signed [17:0] y2;
  logic signed [17:0] yl;
  logic signed [17:0] top;
  logic signed [17:0] bot;
  logic signed [crmx_pkg::XW-1:0] xr;
  logic signed [crmx_pkg::XW-1:0] yr;

  assign ready = !valid || dn_ready;
  assign up_ready = !s1_valid || ready;

  always_comb begin
    tl = $signed({2'b00, cfg.thrust_limit});
    thr = 17'($signed(up.thrust_cmd));
    if (thr < -tl) begin
      thr_c = -tl;
    end else if (thr > tl) begin
      thr_c = tl;
    end else begin
      thr_c = thr;
    end
    rsq_s = $signed(up.roll_cmd) * $signed(up.roll_cmd);
    psq_s = $signed(up.pitch_cmd) * $signed(up.pitch_cmd);
    s1_next.thrust = thr_c[15:0];
    s1_next.yaw = up.yaw_cmd;
    s1_next.roll = up.roll_cmd;
    s1_next.pitch = up.pitch_cmd;
    s1_next.rsq = $unsigned(rsq_s);
    s1_next.psq = $unsigned(psq_s);
    s1_next.slow = up.rotor_speed < crmx_pkg::SLOW_SPEED;
  end

  always_comb begin
    t = 18'($signed(s1.thrust));
    yw = 18'($signed(s1.yaw));
    if (yw < -t) begin
      y1 = -t;
    end else if (yw > t) begin
      y1 = t;
    end else begin
      y1 = yw;
    end
    yl = $signed({3'b000, cfg.yaw_limit});
    if (y1 < -yl) begin
      y2 = -yl;
    end else if (y1 > yl) begin
      y2 = yl;
    end else begin
      y2 = y1;
    end
    top = t - y2;
    bot = cfg.bottom_enable ? t + y2 : '0;

    xr = $signed({{3{s1.roll[15]}}, s1.roll, 14'b0});
    yr = $signed({{3{s1.pitch[15]}}, s1.pitch, 14'b0});

    q_next.carry.upper_drive = top[16:0];
    q_next.carry.lower_drive = bot[16:0];
    q_next.carry.slow = s1.slow;
    q_next.zero = (s1.roll == '0) && (s1.pitch == '0);
    q_next.s = s1.rsq + s1.psq;
    q_next.r = '0;
    if (xr < 0) begin
      if (yr >= 0) begin
        q_next.x = yr;
        q_next.y = -xr;
        q_next.z = crmx_pkg::HALF_PI_FINE;
      end else begin
        q_next.x = -yr;
        q_next.y = xr;
        q_next.z = -crmx_pkg::HALF_PI_FINE;
      end
    end else begin
      q_next.x = xr;
      q_next.y = yr;
      q_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (up_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && s1_valid) begin
      q <= q_next;
    end
  end

endmodule

[rtl/core/crmx_cell.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer cell
// One vectoring rotation step and one square root digit, with a stage register.
// ----------------------------------------------------------------------------
module crmx_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  crmx_pkg::work_t up,
  output logic            up_ready,
  output logic            valid,
  output crmx_pkg::work_t q,
  input  logic            dn_ready
);

  localparam logic signed [crmx_pkg::ZW-1:0] AtanStep = crmx_pkg::ATAN_FINE[STEP];
  localparam logic [31:0] SqBit = 32'(1) << (30 - 2 * STEP);

  crmx_pkg::work_t q_next;
  logic signed [crmx_pkg::XW-1:0] xs;
  logic signed [crmx_pkg::XW-1:0] ys;
  logic [32:0] trial;

  assign up_ready = !valid || dn_ready;
  assign xs = $signed(up.x) >>> STEP;
  assign ys = $signed(up.y) >>> STEP;
  assign trial = {1'b0, up.r} + {1'b0, SqBit};

  always_comb begin
    q_next = up;
    if (!up.y[crmx_pkg::XW-1]) begin
      q_next.x = $signed(up.x) + ys;
      q_next.y = $signed(up.y) - xs;
      q_next.z = $signed(up.z) + AtanStep;
    end else begin
      q_next.x = $signed(up.x) - ys;
      q_next.y = $signed(up.y) + xs;
      q_next.z = $signed(up.z) - AtanStep;
    end
    if ({1'b0, up.s} >= trial) begin
      q_next.s = up.s - trial[31:0];
      q_next.r = (up.r >> 1) + SqBit;
    end else begin
      q_next.r = up.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q <= q_next;
    end
  end

endmodule

[rtl/core/crmx_back.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer back end
// Rounds the angle, shapes the pulse amplitude and wraps the corrected phase.
// ----------------------------------------------------------------------------
module crmx_back (
  input  logic            clk,
  input  logic            rst,
  input  crmx_pkg::cfg_t  cfg,
  input  logic            up_valid,
  input  crmx_pkg::work_t up,
  output logic            up_ready,
  output logic            valid,
  output crmx_pkg::drv_t  q,
  input  logic            dn_ready
);

  typedef struct packed {
    crmx_pkg::carry_t carry;
    logic [14:0]      raw;
    logic [16:0]      amp;
  } back_t;

  logic s1_valid;
  back_t s1;
  back_t s1_next;
  crmx_pkg::drv_t q_next;
  logic ready;

  logic signed [crmx_pkg::ZW-1:0] zr;
  logic [15:0] mag;
  logic signed [16:0] ph;
  logic [16:0] amp;

  assign ready = !valid || dn_ready;
  assign up_ready = !s1_valid || ready;

  always_comb begin
    zr = ($signed(up.z) + 20'sd8) >>> 4;
    s1_next.carry = up.carry;
    if (up.zero) begin
      s1_next.raw = '0;
    end else if (zr > 20'($signed(crmx_pkg::PHASE_PI))) begin
      s1_next.raw = crmx_pkg::PHASE_PI;
    end else if (zr < -20'($signed(crmx_pkg::PHASE_PI))) begin
      s1_next.raw = -crmx_pkg::PHASE_PI;
    end else begin
      s1_next.raw = zr[14:0];
    end
    mag = up.r[15:0];
    if (mag < {1'b0, cfg.pulse_threshold}) begin
      s1_next.amp = '0;
    end else begin
      s1_next.amp = {1'b0, mag} + {2'b00, cfg.pulse_offset};
    end
  end

  always_comb begin
    ph = 17'($signed(cfg.phase_advance)) - 17'($signed(s1.raw));
    if (ph > crmx_pkg::PHASE_PI_W) begin
      ph = ph - crmx_pkg::PHASE_TWO_PI;
    end else if (ph < -crmx_pkg::PHASE_PI_W) begin
      ph = ph + crmx_pkg::PHASE_TWO_PI;
    end
    if (s1.carry.slow) begin
      amp = '0;
    end else if (s1.amp > {2'b00, cfg.pulse_limit}) begin
      amp = {2'b00, cfg.pulse_limit};
    end else begin
      amp = s1.amp;
    end
    q_next.upper_drive = s1.carry.upper_drive;
    q_next.lower_drive = s1.carry.lower_drive;
    q_next.pulse_amplitude = amp[14:0];
    q_next.pulse_phase = ph[14:0];
    q_next.raw_phase = s1.raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (up_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && s1_valid) begin
      q <= q_next;
    end
  end

endmodule

[rtl/core/coax_rotor_command_mixer.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer
// Mixes one attitude command into mean motor drives and a top rotor pulse.
//
// Channel   Direction  Handshake            Beat
// cmd       in         cmd_valid/cmd_stall  thrust, yaw, roll, pitch, speed
// drv       out        drv_valid/drv_stall  means, pulse amplitude and phase
// cfg       in         cfg_valid/cfg_ready  register index and write data
//
// A command beat is accepted every cycle while cmd_stall is low; its result
// passes through the row of 16 rotation and square root cells plus two
// front and two back stages. Each stage moves on when the next one is free,
// so a stalled output fills the row before cmd_stall rises. Reset clears every
// stage valid and loads the register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
`include "coax_rotor_command_mixer_defines.svh"

module coax_rotor_command_mixer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  crmx_pkg::cmd_t cmd_data,
  output logic           drv_valid,
  input  logic           drv_stall,
  output crmx_pkg::drv_t drv_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [14:0]    cfg_data
);

  crmx_pkg::cfg_t cfg_q;
  logic cmd_ready;
  logic phase_ok;
  logic enable_write;

  logic            cv [crmx_pkg::CORDIC_STEPS+1];
  logic            cr [crmx_pkg::CORDIC_STEPS+1];
  crmx_pkg::work_t cw [crmx_pkg::CORDIC_STEPS+1];

  assign cfg_ready = 1'b1;
  assign cmd_stall = !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= crmx_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (crmx_pkg::reg_idx_t'(cfg_index))
        crmx_pkg::REG_THRUST_LIMIT:    cfg_q.thrust_limit <= cfg_data;
        crmx_pkg::REG_YAW_LIMIT:       cfg_q.yaw_limit <= cfg_data;
        crmx_pkg::REG_PULSE_THRESHOLD: cfg_q.pulse_threshold <= cfg_data;
        crmx_pkg::REG_PULSE_OFFSET:    cfg_q.pulse_offset <= cfg_data;
        crmx_pkg::REG_PULSE_LIMIT:     cfg_q.pulse_limit <= cfg_data;
        crmx_pkg::REG_PHASE_ADVANCE:   cfg_q.phase_advance <= cfg_data;
        crmx_pkg::REG_BOTTOM_ENABLE:   cfg_q.bottom_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  crmx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .up_valid (cmd_valid),
    .up       (cmd_data),
    .up_ready (cmd_ready),
    .valid    (cv[0]),
    .q        (cw[0]),
    .dn_ready (cr[0])
  );

  for (genvar i = 0; i < crmx_pkg::CORDIC_STEPS; i++) begin : g_cell
    crmx_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cv[i]),
      .up       (cw[i]),
      .up_ready (cr[i]),
      .valid    (cv[i+1]),
      .q        (cw[i+1]),
      .dn_ready (cr[i+1])
    );
  end

  crmx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .up_valid (cv[crmx_pkg::CORDIC_STEPS]),
    .up       (cw[crmx_pkg::CORDIC_STEPS]),
    .up_ready (cr[crmx_pkg::CORDIC_STEPS]),
    .valid    (drv_valid),
    .q        (drv_data),
    .dn_ready (!drv_stall)
  );

  assign phase_ok = ($signed(drv_data.pulse_phase) <= crmx_pkg::PHASE_PI) &&
                    ($signed(drv_data.pulse_phase) >= -crmx_pkg::PHASE_PI);
  assign enable_write = cfg_valid && cfg_ready &&
                        (cfg_index == crmx_pkg::REG_BOTTOM_ENABLE);

  `CRMX_ASSERT_NOW(a_empty_out_never_stalls, clk, rst, !drv_valid, !cmd_stall)
  `CRMX_ASSERT_NOW(a_amp_capped, clk, rst, drv_valid, drv_data.pulse_amplitude <= cfg_q.pulse_limit)
  `CRMX_ASSERT_NOW(a_phase_wrapped, clk, rst, drv_valid, phase_ok)
  `CRMX_ASSERT_NOW(a_bottom_off, clk, rst, drv_valid && !cfg_q.bottom_enable, drv_data.lower_drive == '0)
  `CRMX_ASSERT_NEXT(a_enable_write, clk, rst, enable_write, cfg_q.bottom_enable == $past(cfg_data[0]))

endmodule

[tb/coax_rotor_command_mixer_checker.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer checker
// Watches the command, drive and register channels, keeps its own copy of the
// registers, works out the drive beat for each accepted command and compares
// every accepted drive beat field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module coax_rotor_command_mixer_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  crmx_pkg::cmd_t cmd_data,
  input  logic           drv_valid,
  input  logic           drv_stall,
  input  crmx_pkg::drv_t drv_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [14:0]    cfg_data,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] thrust_limit;
    logic [14:0] yaw_limit;
    logic [14:0] pulse_threshold;
    logic [14:0] pulse_offset;
    logic [14:0] pulse_limit;
    logic [14:0] phase_advance;
    logic        bottom_enable;
  } mixer_regs_t;

  localparam mixer_regs_t REGS_AT_RESET = '{
    thrust_limit:    15'd5734,
    yaw_limit:       15'd1536,
    pulse_threshold: 15'd57,
    pulse_offset:    15'd1536,
    pulse_limit:     15'd4096,
    phase_advance:   15'(-3277),
    bottom_enable:   1'b1
  };

  localparam longint ANGLE_PI        = 12868;
  localparam longint ANGLE_TWO_PI    = 25736;
  localparam longint HALF_PI_Q16     = 102944;
  localparam longint MIN_PULSE_SPEED = 1600;

  mixer_regs_t    regs;
  crmx_pkg::drv_t owed_drives[$];

  function automatic longint arctan_q16(int i);
    case (i)
      0:       return 51472;
      1:       return 30385;
      2:       return 16054;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      default: return 2;
    endcase
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint root_floor(longint s);
    longint r;
    longint probe;
    r = 0;
    probe = 64'sh4000_0000_0000_0000;
    while (probe > s) probe = probe >>> 2;
    while (probe != 0) begin
      if (s >= r + probe) begin
        s = s - (r + probe);
        r = (r >>> 1) + probe;
      end else begin
        r = r >>> 1;
      end
      probe = probe >>> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC on the roll/pitch vector, angle kept in 2^-16 rad.
  function automatic longint pulse_angle(longint py, longint px);
    longint x;
    longint y;
    longint z;
    longint t;
    int     i;
    if (px == 0 && py == 0) return 0;
    x = px * 16384;
    y = py * 16384;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q16;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q16;
      end
    end
    for (i = 0; i < 16; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + arctan_q16(i);
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - arctan_q16(i);
      end
    end
    return bound((z + 8) >>> 4, -ANGLE_PI, ANGLE_PI);
  endfunction

  function automatic crmx_pkg::drv_t predict_drive(crmx_pkg::cmd_t c, mixer_regs_t r);
    longint         thrust;
    longint         yaw;
    longint         roll;
    longint         pitch;
    longint         raw;
    longint         mag;
    longint         amp;
    longint         ph;
    longint         top;
    longint         bottom;
    crmx_pkg::drv_t d;
    thrust = longint'($signed(c.thrust_cmd));
    yaw    = longint'($signed(c.yaw_cmd));
    roll   = longint'($signed(c.roll_cmd));
    pitch  = longint'($signed(c.pitch_cmd));

    thrust = bound(thrust, -longint'(r.thrust_limit), longint'(r.thrust_limit));
    yaw    = bound(yaw, -thrust, thrust);
    yaw    = bound(yaw, -longint'(r.yaw_limit), longint'(r.yaw_limit));
    top    = thrust - yaw;
    bottom = r.bottom_enable ? thrust + yaw : 0;

    raw = pulse_angle(pitch, roll);
    mag = root_floor(roll * roll + pitch * pitch);
    if (mag < longint'(r.pulse_threshold)) amp = 0;
    else amp = mag + longint'(r.pulse_offset);
    if (amp > longint'(r.pulse_limit)) amp = longint'(r.pulse_limit);
    if (longint'(c.rotor_speed) < MIN_PULSE_SPEED) amp = 0;

    ph = longint'($signed(r.phase_advance)) - raw;
    while (ph > ANGLE_PI) ph = ph - ANGLE_TWO_PI;
    while (ph < -ANGLE_PI) ph = ph + ANGLE_TWO_PI;

    d.upper_drive     = top[16:0];
    d.lower_drive     = bottom[16:0];
    d.pulse_amplitude = amp[14:0];
    d.pulse_phase     = ph[14:0];
    d.raw_phase       = raw[14:0];
    return d;
  endfunction

  task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      fail_count = fail_count + 1;
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    regs = REGS_AT_RESET;
  end

  always @(posedge clk) begin
    crmx_pkg::drv_t want;
    if (rst) begin
      regs = REGS_AT_RESET;
      owed_drives.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (crmx_pkg::reg_idx_t'(cfg_index))
          crmx_pkg::REG_THRUST_LIMIT:    regs.thrust_limit = cfg_data;
          crmx_pkg::REG_YAW_LIMIT:       regs.yaw_limit = cfg_data;
          crmx_pkg::REG_PULSE_THRESHOLD: regs.pulse_threshold = cfg_data;
          crmx_pkg::REG_PULSE_OFFSET:    regs.pulse_offset = cfg_data;
          crmx_pkg::REG_PULSE_LIMIT:     regs.pulse_limit = cfg_data;
          crmx_pkg::REG_PHASE_ADVANCE:   regs.phase_advance = cfg_data;
          crmx_pkg::REG_BOTTOM_ENABLE:   regs.bottom_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) owed_drives.push_back(predict_drive(cmd_data, regs));
      if (drv_valid && !drv_stall) begin
        if (owed_drives.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: drive beat with none expected, actual %h", $time, drv_data);
        end else begin
          want = owed_drives.pop_front();
          check_field("upper_drive", want.upper_drive, drv_data.upper_drive);
          check_field("lower_drive", want.lower_drive, drv_data.lower_drive);
          check_field("pulse_amplitude", {2'b00, want.pulse_amplitude},
                      {2'b00, drv_data.pulse_amplitude});
          check_field("pulse_phase", {2'b00, want.pulse_phase}, {2'b00, drv_data.pulse_phase});
          check_field("raw_phase", {2'b00, want.raw_phase}, {2'b00, drv_data.raw_phase});
        end
      end
    end
    pending = owed_drives.size();
  end

endmodule

[tb/tb_coax_rotor_command_mixer.sv]
// ----------------------------------------------------------------------------
// Coax rotor command mixer testbench
// Drives directed and random command beats through several register settings,
// with random gaps on the command side, random stalls on the drive side and
// one long drive hold-off that backs the pipeline up into the command port.
// The checker beside the block predicts and compares every drive beat.
// ----------------------------------------------------------------------------
module tb_coax_rotor_command_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RUN_LIMIT    = 400000;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         RANDOM_BEATS = 90;
  localparam int         BURST_BEATS  = 70;
  localparam logic [2:0] REG_UNUSED   = 3'd7;

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  crmx_pkg::cmd_t cmd_data;
  logic           drv_valid;
  logic           drv_stall;
  crmx_pkg::drv_t drv_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [2:0]     cfg_index;
  logic [14:0]    cfg_data;
  int             fail_count;
  int             pending;
  bit             hold_off;
  bit             no_gaps;

  coax_rotor_command_mixer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .drv_valid (drv_valid),
    .drv_stall (drv_stall),
    .drv_data  (drv_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  coax_rotor_command_mixer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_data   (cmd_data),
    .drv_valid  (drv_valid),
    .drv_stall  (drv_stall),
    .drv_data   (drv_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("** coax_rotor_command_mixer: FAILED **");
    $finish;
  end

  // Drive side: random stall runs, mostly short, with the occasional long
  // stall or long free stretch, plus one requested hold-off.
  initial begin
    int run_left;
    int pick;
    run_left = 0;
    drv_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        drv_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
        run_left = 0;
      end else if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          drv_stall <= 1'b0;
          run_left = $urandom_range(1, 8);
        end else if (pick < 85) begin
          drv_stall <= 1'b1;
          run_left = $urandom_range(1, 3);
        end else if (pick < 95) begin
          drv_stall <= 1'b0;
          run_left = $urandom_range(20, 60);
        end else begin
          drv_stall <= 1'b1;
          run_left = $urandom_range(15, 40);
        end
      end else begin
        run_left = run_left - 1;
      end
    end
  end

  function automatic crmx_pkg::cmd_t make_cmd(int thrust, int yaw, int roll, int pitch,
                                              int speed);
    crmx_pkg::cmd_t c;
    c.thrust_cmd  = thrust[15:0];
    c.yaw_cmd     = yaw[15:0];
    c.roll_cmd    = roll[15:0];
    c.pitch_cmd   = pitch[15:0];
    c.rotor_speed = speed[15:0];
    return c;
  endfunction

  function automatic logic [15:0] random_volts();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = $urandom_range(0, 400) - 200;
      3, 4:    v = $urandom_range(0, 12000) - 6000;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] random_speed();
    int v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(1596, 1604);
      1:       v = 0;
      2:       v = 65535;
      3:       v = $urandom_range(0, 1599);
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic crmx_pkg::cmd_t random_cmd();
    crmx_pkg::cmd_t c;
    c.thrust_cmd  = random_volts();
    c.yaw_cmd     = random_volts();
    c.roll_cmd    = random_volts();
    c.pitch_cmd   = random_volts();
    c.rotor_speed = random_speed();
    return c;
  endfunction

  function automatic int beat_gap();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_cmd(crmx_pkg::cmd_t c);
    int gap;
    gap = beat_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic send_random(int count);
    repeat (count) send_cmd(random_cmd());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(int thrust_lim, int yaw_lim, int threshold, int offset,
                           int pulse_lim, int advance, int bottom_on);
    write_reg(crmx_pkg::REG_THRUST_LIMIT, thrust_lim[14:0]);
    write_reg(crmx_pkg::REG_YAW_LIMIT, yaw_lim[14:0]);
    write_reg(crmx_pkg::REG_PULSE_THRESHOLD, threshold[14:0]);
    write_reg(crmx_pkg::REG_PULSE_OFFSET, offset[14:0]);
    write_reg(crmx_pkg::REG_PULSE_LIMIT, pulse_lim[14:0]);
    write_reg(crmx_pkg::REG_PHASE_ADVANCE, advance[14:0]);
    write_reg(crmx_pkg::REG_BOTTOM_ENABLE, bottom_on[14:0]);
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_off  = 1'b0;
    no_gaps   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults from reset.
    send_cmd(make_cmd(0, 0, 0, 0, 0));
    send_cmd(make_cmd(32767, 32767, 32767, 0, 65535));
    send_cmd(make_cmd(-32768, -32768, -32768, -32768, 65535));
    send_cmd(make_cmd(-1000, 500, 100, 100, 2000));
    send_cmd(make_cmd(-1000, 2000, -100, 0, 1600));
    send_cmd(make_cmd(-1000, -3000, -100, -1, 1599));
    send_cmd(make_cmd(6000, -6000, 0, 100, 1600));
    send_cmd(make_cmd(-6000, 6000, 0, -100, 1600));
    send_cmd(make_cmd(100, 50, 57, 0, 3000));
    send_cmd(make_cmd(100, -50, 56, 0, 3000));
    send_cmd(make_cmd(0, 0, 40, 40, 3000));
    send_cmd(make_cmd(0, 0, 41, 41, 3000));
    send_cmd(make_cmd(0, 0, -32768, 1, 3000));
    send_cmd(make_cmd(0, 0, -32768, -1, 3000));
    send_cmd(make_cmd(0, 0, 32767, -32768, 3000));
    send_cmd(make_cmd(0, 0, 3000, 3000, 1600));
    send_cmd(make_cmd(0, 0, -3000, 3000, 1599));
    send_cmd(make_cmd(5734, 1536, 1, -1, 65535));
    send_cmd(make_cmd(-5734, -1536, -1, 1, 1));
    send_random(RANDOM_BEATS);

    wait_idle();
    write_all(32767, 32767, 0, 32767, 32767, 12868, 0);
    send_random(RANDOM_BEATS);

    wait_idle();
    write_all(0, 0, 32767, 0, 0, -12868, 1);
    write_reg(REG_UNUSED, 15'($urandom));
    send_random(RANDOM_BEATS);

    wait_idle();
    write_all($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 3000),
              $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom,
              $urandom_range(0, 1));
    send_random(RANDOM_BEATS);

    wait_idle();
    write_all(8000, 3000, 100, 500, 10000, 0, 1);
    hold_off = 1'b1;
    no_gaps  = 1'b1;
    send_random(BURST_BEATS);
    no_gaps  = 1'b0;
    send_random(RANDOM_BEATS - BURST_BEATS + 10);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** coax_rotor_command_mixer: PASSED **");
    end else begin
      $display("** coax_rotor_command_mixer: FAILED **");
    end
    $finish;
  end

endmodule
